@@ src/iptm_pkg.sv @@
// Shared types and codes for the IP-to-MAC address resolution table.
// Used by iptm_cell, ip_to_mac_table and iptm_checker; depends on nothing.
package iptm_pkg;

    // Default table capacity
    localparam int unsigned IPTM_ENTRIES = 16;

    // Operation codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_HIT      = 3'd3;
    localparam logic [2:0] ST_MISS     = 3'd4;

    // Request beat as it walks the cell row, with the answer built so far
    typedef struct packed {
        logic        op;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        done;
        logic        found;
        logic [2:0]  status;
        logic [47:0] mac_out;
    } tok_t;

endpackage

@@ src/ip_to_mac_table.sv @@
// IP-to-MAC address resolution table. Entries fill in order from index 0 and
// are never evicted. Each accepted request beat walks a row of ENTRIES cells,
// registered in every cell, and its result is then captured in the output
// register; a new request is taken only once that result has been taken.
// Update: overwrite the first matching entry, else append, else drop as full.
// Lookup: report the first matching entry's MAC, or a miss with MAC zero.
// Depends on iptm_pkg and iptm_cell.
module ip_to_mac_table
    import iptm_pkg::*;
#(
    parameter int unsigned ENTRIES = IPTM_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_ip_address,
    input  logic [47:0] s_mac_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_found,
    output logic [47:0] m_mac_result
);

    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             m_valid_reg;
    logic [2:0]       m_status_reg;
    logic             m_found_reg;
    logic [47:0]      m_mac_reg;

    logic             chain_valid [0:ENTRIES];
    tok_t             chain_tok   [0:ENTRIES];
    logic             s_beat;
    logic             tail_valid;
    tok_t             tail_tok;
    logic [2:0]       tail_status;

    assign s_ready = !busy_reg;
    assign s_beat  = s_valid && !busy_reg;

    // Build the head beat from the input ports
    always_comb begin
        chain_valid[0]       = s_beat;
        chain_tok[0].op      = s_opcode;
        chain_tok[0].ip      = s_ip_address;
        chain_tok[0].mac     = s_mac_value;
        chain_tok[0].done    = 1'b0;
        chain_tok[0].found   = 1'b0;
        chain_tok[0].status  = ST_MISS;
        chain_tok[0].mac_out = '0;
    end

    // Row of table cells
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        iptm_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .fill_count    (fill_reg),
            .tok_valid_in  (chain_valid[i]),
            .tok_in        (chain_tok[i]),
            .tok_valid_out (chain_valid[i+1]),
            .tok_out       (chain_tok[i+1])
        );
    end

    assign tail_valid = chain_valid[ENTRIES];
    assign tail_tok   = chain_tok[ENTRIES];

    // Settle a beat that no cell claimed
    always_comb begin
        if (tail_tok.done) begin
            tail_status = tail_tok.status;
        end else if (tail_tok.op == OP_UPDATE) begin
            tail_status = ST_FULL;
        end else begin
            tail_status = ST_MISS;
        end
    end

    // Control: one beat in flight, fill count bumped when the beat retires
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_beat) begin
                busy_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                busy_reg <= 1'b0;
            end
            if (tail_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (tail_valid && tail_status == ST_INSERTED) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (tail_valid) begin
            m_status_reg <= tail_status;
            m_found_reg  <= tail_tok.found;
            m_mac_reg    <= tail_tok.mac_out;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found      = m_found_reg;
    assign m_mac_result = m_mac_reg;

endmodule

@@ src/iptm_cell.sv @@
// One entry of the address table: holds a key and a MAC, matches the passing
// request beat against them and hands the beat on to the next cell.
// Depends on iptm_pkg.
module iptm_cell
    import iptm_pkg::*;
#(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] fill_count,
    input  logic             tok_valid_in,
    input  tok_t             tok_in,
    output logic             tok_valid_out,
    output tok_t             tok_out
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [31:0] key_reg;
    logic [47:0] mac_reg;
    logic        tok_valid_reg;
    tok_t        tok_out_reg;
    tok_t        tok_next;
    logic        entry_hit;
    logic        entry_free;

    // Match a live entry, or claim this slot when it is the first empty one
    assign entry_hit  = tok_valid_in && !tok_in.done && (IDX_C < fill_count)
                        && (key_reg == tok_in.ip);
    assign entry_free = tok_valid_in && !tok_in.done && (IDX_C == fill_count)
                        && (tok_in.op == OP_UPDATE);

    // Resolve the beat here if this cell decides it
    always_comb begin
        tok_next = tok_in;
        if (entry_hit) begin
            tok_next.done  = 1'b1;
            tok_next.found = 1'b1;
            if (tok_in.op == OP_UPDATE) begin
                tok_next.status = ST_UPDATED;
            end else begin
                tok_next.status  = ST_HIT;
                tok_next.mac_out = mac_reg;
            end
        end else if (entry_free) begin
            tok_next.done   = 1'b1;
            tok_next.status = ST_INSERTED;
        end
    end

    // Write the entry on insert or overwrite
    always_ff @(posedge aclk) begin
        if (entry_free) begin
            key_reg <= tok_in.ip;
            mac_reg <= tok_in.mac;
        end else if (entry_hit && tok_in.op == OP_UPDATE) begin
            mac_reg <= tok_in.mac;
        end
    end

    // Advance the beat one cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_valid_in) begin
            tok_out_reg <= tok_next;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_out_reg;

endmodule

@@ src/iptm_checker.sv @@
// Port-level checks for ip_to_mac_table, attached by the bind at the end.
// Depends on iptm_pkg.
module iptm_checker
    import iptm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic        m_found,
    input logic [47:0] m_mac_result
);

    // Take no new beat while one is in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another was in flight");

    // Flag found exactly on overwrite or lookup hit
    a_found_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_found == (m_status == ST_UPDATED || m_status == ST_HIT)))
        else $error("found flag disagrees with status");

    // Drive MAC zero except on a lookup hit
    a_mac_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_HIT |-> m_mac_result == 48'd0)
        else $error("nonzero MAC outside a lookup hit");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found)
            && $stable(m_mac_result))
        else $error("stalled result changed");

endmodule

bind ip_to_mac_table iptm_checker u_iptm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_found      (m_found),
    .m_mac_result (m_mac_result)
);
